// ===== design/assert_macros.svh =====
// Assertion helpers shared by the receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPFR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CPFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/cpfr_pkg.sv =====
package cpfr_pkg;

   // Frame layout.
   localparam logic [7:0] START_MARK = 8'hAA;
   localparam logic [7:0] END_MARK   = 8'h55;
   localparam logic [3:0] LAST_POS   = 4'd10;
   localparam int         BODY_BYTES = 8;

   // Request kinds carried on the request tuser bit.
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Values latched from the last frame that passed its checks.
   typedef struct packed {
      logic [15:0]       button_word;
      logic [7:0]        left_trigger;
      logic [7:0]        right_trigger;
      logic signed [7:0] right_y;
      logic signed [7:0] right_x;
      logic signed [7:0] left_y;
      logic signed [7:0] left_x;
   } latch_type;

   // Newly pressed buttons handed to the event queue.
   typedef struct packed {
      logic        push;
      logic [15:0] mask;
   } push_type;

endpackage

// ===== design/cpfr_deframe.sv =====
module cpfr_deframe (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_accept,
   input  logic [7:0]          rx_byte,
   output logic                frame_ok,
   output cpfr_pkg::latch_type latch,
   output cpfr_pkg::push_type  event_push
);
   import cpfr_pkg::*;

   logic [3:0]  pos_ff;
   logic [3:0]  pos_in;
   logic [7:0]  sum_ff;
   logic [7:0]  sum_in;
   logic [7:0]  body_ff [BODY_BYTES];
   logic [15:0] prev_buttons_ff;
   latch_type   latch_ff;
   logic [15:0] buttons;
   logic        at_end;

   // Bytes seven and eight hold the button word, low byte first.
   assign buttons = {body_ff[7], body_ff[6]};
   assign at_end  = byte_accept && (rx_byte != START_MARK) && (pos_ff == LAST_POS);

   // The running sum covers bytes zero to nine, so a good checksum leaves it at zero.
   assign frame_ok = at_end && (rx_byte == END_MARK) && (sum_ff == 8'd0);

   // Position and running sum; a start mark always restarts the frame.
   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (byte_accept) begin
         if (rx_byte == START_MARK) begin
            pos_in = 4'd1;
            sum_in = START_MARK;
         end else if (pos_ff == LAST_POS || pos_ff == 4'd0) begin
            pos_in = 4'd0;
         end else begin
            pos_in = pos_ff + 4'd1;
            sum_in = sum_ff + rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 4'd0;
      end else begin
         pos_ff <= pos_in;
      end
      sum_ff <= sum_in;
   end

   // Body bytes one to eight are kept at fixed places.
   always_ff @(posedge clock) begin
      for (int i = 0; i < BODY_BYTES; i++) begin
         if (byte_accept && rx_byte != START_MARK && pos_ff == 4'(i + 1)) begin
            body_ff[i] <= rx_byte;
         end
      end
   end

   // Latches and the previous button word change only on a good frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff        <= '0;
         prev_buttons_ff <= 16'd0;
      end else if (frame_ok) begin
         latch_ff.left_x        <= body_ff[0];
         latch_ff.left_y        <= body_ff[1];
         latch_ff.right_x       <= body_ff[2];
         latch_ff.right_y       <= body_ff[3];
         latch_ff.right_trigger <= body_ff[4];
         latch_ff.left_trigger  <= body_ff[5];
         latch_ff.button_word   <= buttons;
         prev_buttons_ff        <= buttons;
      end
   end

   assign latch           = latch_ff;
   assign event_push.mask = buttons & ~prev_buttons_ff;
   assign event_push.push = frame_ok && (event_push.mask != 16'd0);

endmodule

// ===== design/cpfr_evq.sv =====
module cpfr_evq #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               pop,
   input  cpfr_pkg::push_type event_push,
   output logic               event_valid,
   output logic [15:0]        event_bits,
   output logic               waiting
);
   import cpfr_pkg::*;

   localparam int              AW   = $clog2(QUEUE_DEPTH);
   localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

   logic [15:0]   mem [QUEUE_DEPTH];
   logic [AW-1:0] head_ff;
   logic [AW-1:0] tail_ff;
   logic [AW-1:0] head_next;
   logic [AW-1:0] tail_next;
   logic          full;
   logic          take;
   logic          event_valid_ff;
   logic [15:0]   event_bits_ff;

   assign head_next = (head_ff == LAST) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == LAST) ? '0 : tail_ff + 1'b1;
   assign full      = (head_next == tail_ff);
   assign waiting   = (head_ff != tail_ff);
   assign take      = accept && pop && waiting;

   // One slot stays free, so a full queue drops the new event.
   always_ff @(posedge clock) begin
      if (event_push.push && !full) begin
         mem[head_ff] <= event_push.mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         if (event_push.push && !full) begin
            head_ff <= head_next;
         end
         if (take) begin
            tail_ff <= tail_next;
         end
      end
   end

   // Registered read of the oldest event; any other request returns zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         event_valid_ff <= 1'b0;
      end else if (accept) begin
         event_valid_ff <= take;
      end
      if (take) begin
         event_bits_ff <= mem[tail_ff];
      end else if (accept) begin
         event_bits_ff <= 16'd0;
      end
   end

   assign event_valid = event_valid_ff;
   assign event_bits  = event_bits_ff;

endmodule

// ===== design/checksummed_pad_frame_receiver.sv =====
// Channel   | Direction | Contents
// req_      | in        | tdata: rx_byte; tuser: op (0 byte, 1 pop)
// rsp_      | out       | one response per request, frame latches and event
//
// One request is taken per cycle; its response is registered and appears the
// next cycle. req_tready is high while the response register is empty or
// being drained, so the stream only stalls when rsp_tready holds it off.
// The frame check is a running 8-bit sum, and the event queue is a memory
// with one write and one registered read port. Synchronous reset clears the
// frame position, latches, queue pointers and response valid.
`include "assert_macros.svh"

module checksummed_pad_frame_receiver #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [0:0]  req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] left_x, [15:8] left_y, [23:16] right_x, [31:24] right_y,
   // [39:32] right_trigger, [47:40] left_trigger, [63:48] button_word,
   // [79:64] event_bits, [80] events_waiting, [87:81] zero
   output logic [87:0] rsp_tdata,
   output logic [1:0]  rsp_tuser    // [0] frame_ok, [1] event_valid
);
   import cpfr_pkg::*;

   logic      accept;
   logic      byte_accept;
   logic      frame_ok;
   logic      frame_ok_ff;
   logic      rsp_valid_ff;
   latch_type latch;
   push_type  event_push;
   logic      event_valid;
   logic [15:0] event_bits;
   logic      waiting;

   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign accept      = req_tvalid && req_tready;
   assign byte_accept = accept && (req_tuser[0] == OP_BYTE);

   cpfr_deframe u_deframe (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req_tdata),
      .frame_ok    (frame_ok),
      .latch       (latch),
      .event_push  (event_push)
   );

   cpfr_evq #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_evq (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pop         (req_tuser[0] == OP_POP),
      .event_push  (event_push),
      .event_valid (event_valid),
      .event_bits  (event_bits),
      .waiting     (waiting)
   );

   // Response valid and the frame flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         frame_ok_ff  <= 1'b0;
      end else begin
         if (accept) begin
            rsp_valid_ff <= 1'b1;
            frame_ok_ff  <= frame_ok;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {event_valid, frame_ok_ff};
   assign rsp_tdata  = {7'd0, waiting, event_bits, latch.button_word,
                        latch.left_trigger, latch.right_trigger,
                        latch.right_y, latch.right_x, latch.left_y, latch.left_x};

   // A response never reports a frame and an event at once.
   `CPFR_ASSERT_SAME(a_flags_exclusive, clock, reset,
                     rsp_tvalid, !(rsp_tuser[0] && rsp_tuser[1]))
   // A pop on a non-empty queue returns an event.
   `CPFR_ASSERT_NEXT(a_pop_gives_event, clock, reset,
                     accept && req_tuser[0] == OP_POP && waiting,
                     rsp_tvalid && rsp_tuser[1])
   // A byte request never returns an event.
   `CPFR_ASSERT_NEXT(a_byte_no_event, clock, reset, byte_accept,
                     rsp_tvalid && !rsp_tuser[1] && rsp_tdata[79:64] == 16'd0)

endmodule
